### rtl/linear_interp_resampler_assert.svh
// assertion macros for the resampler rtl
// no dependencies; include by bare file name inside a module body
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define LIR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// condition in this cycle implies consequence in the next cycle
`define LIR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

### rtl/lir_pkg.sv
// shared constants and types for the linear interpolation resampler
// no dependencies
package lir_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int LEN_W      = 21;
  localparam int MAX_LENGTH = 1048576;
  localparam int DIV_W      = LEN_W - 1;
  localparam int FRAC_W     = 16;
  localparam int MAX_RUN    = 64;
  localparam int RUN_W      = $clog2(MAX_RUN + 1);
  localparam int STEP_W     = $clog2(DIV_W + 1);
  localparam int PROD_W     = SAMPLE_W + 1 + FRAC_W + 1;
  localparam int CFG_IDX_W  = 1;

  // half of one output lsb, added before the fraction bits are dropped
  localparam logic signed [PROD_W:0] ROUND_BIAS =
    {{(PROD_W - FRAC_W + 1){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 1'd1;

  // command to the shared divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage

### rtl/lir_div.sv
// shared radix-2 restoring divider, one quotient bit per cycle
// depends on lir_pkg
module lir_div import lir_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_cmd_t         cmd,
  input  logic [DIV_W-1:0] divisor,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [DIV_W-1:0] rem
);

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  dsr;
  logic [DIV_W-1:0]  bits;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem, bits[DIV_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
        dsr  <= divisor;
        rem  <= rem_init;
        bits <= dividend;
        quot <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], ge};
        bits <= {bits[DIV_W-2:0], 1'b0};
        cnt  <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/lir_lerp.sv
// two-stage interpolation unit: a + round((b - a) * frac / 2^16)
// depends on lir_pkg
module lir_lerp import lir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  input  logic [FRAC_W-1:0]          frac,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] result
);

  logic signed [SAMPLE_W:0]   diff;
  logic signed [PROD_W-1:0]   prod_next;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] a_d;
  logic                       prod_vld;
  logic signed [PROD_W:0]     biased;
  logic [SAMPLE_W-1:0]        sum;

  // stage 1: difference times fraction
  assign diff      = (SAMPLE_W + 1)'(b) - (SAMPLE_W + 1)'(a);
  assign prod_next = diff * $signed({1'b0, frac});

  // stage 2: round half up, drop fraction bits, add base sample
  assign biased = (PROD_W + 1)'(prod) + ROUND_BIAS;
  assign sum    = a_d + biased[FRAC_W +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      done     <= 1'b0;
    end else begin
      prod_vld <= start;
      done     <= prod_vld;
      if (start) begin
        prod <= prod_next;
        a_d  <= a;
      end
      if (prod_vld) begin
        result <= $signed(sum);
      end
    end
  end

endmodule

### rtl/linear_interp_resampler.sv
// Linear interpolation resampler. Samples of one block arrive one per input
// transfer; each transfer releases the outputs whose two neighbors are now
// known, the final one flagged by last, at most 64 per input. After a
// configuration write the block divides for the step ratio (N-1)/(M-1) on
// the shared divider, if N is nonzero and M is above one, before it takes
// input. Per output, an interpolated point waits on the shared divider for
// the fraction (not when M is one) and then on the multiplier stages; a
// point on an exact sample skips both, and an output past the cap is dropped.
// Output backpressure stalls the sequencer.
// depends on lir_pkg, lir_div, lir_lerp and linear_interp_resampler_assert.svh
module linear_interp_resampler import lir_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [LEN_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] value,
  output logic                       last
);

`include "linear_interp_resampler_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATIO,
    ST_CHECK,
    ST_FRAC,
    ST_MUL,
    ST_ADV,
    ST_PUT
  } state_t;

  state_t                     state;
  logic [LEN_W-1:0]           source_length;
  logic [LEN_W-1:0]           target_length;
  logic                       ratio_pending;
  logic [DIV_W-1:0]           ratio_q;
  logic [DIV_W-1:0]           ratio_r;
  logic signed [SAMPLE_W-1:0] prev_sample;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic signed [SAMPLE_W-1:0] result;
  logic [LEN_W-1:0]           input_count;
  logic [LEN_W-1:0]           output_index;
  logic [LEN_W-1:0]           pos_int;
  logic [DIV_W-1:0]           pos_rem;
  logic [RUN_W-1:0]           run_count;

  logic [LEN_W-1:0]           n_len;
  logic [LEN_W-1:0]           m_len;
  logic [DIV_W-1:0]           den;
  logic [DIV_W-1:0]           n_m1;
  logic                       due;
  logic                       more;
  logic                       run_open;
  logic [LEN_W-1:0]           output_index_next;
  logic [DIV_W:0]             rem_sum;
  logic                       rem_wrap;
  logic [DIV_W-1:0]           pos_rem_next;
  logic [LEN_W-1:0]           pos_int_next;
  logic                       step_on;
  logic                       out_free;

  div_cmd_t                   div_cmd;
  logic [DIV_W-1:0]           div_rem_init;
  logic [DIV_W-1:0]           div_dividend;
  logic                       div_done;
  logic [DIV_W-1:0]           div_quot;
  logic [DIV_W-1:0]           div_rem;
  logic                       ratio_start;
  logic                       frac_start;

  logic                       lerp_start;
  logic [FRAC_W-1:0]          lerp_frac;
  logic                       lerp_done;
  logic signed [SAMPLE_W-1:0] lerp_result;

  // lengths clamped to the supported maximum
  assign n_len = (source_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : source_length;
  assign m_len = (target_length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : target_length;
  assign den   = (m_len == '0) ? '0 : DIV_W'(m_len - LEN_W'(1));
  assign n_m1  = DIV_W'(n_len - LEN_W'(1));

  // next output is due once both neighbors have arrived
  assign due      = (pos_int < input_count) || ((pos_int == input_count) && (pos_rem == '0));
  assign more     = (output_index < m_len) && due;
  assign run_open = run_count < RUN_W'(MAX_RUN);

  // position advance by one output step
  assign output_index_next = output_index + LEN_W'(1);
  assign step_on           = output_index_next < m_len;
  assign rem_sum           = {1'b0, pos_rem} + {1'b0, ratio_r};
  assign rem_wrap          = rem_sum >= {1'b0, den};
  assign pos_rem_next      = rem_wrap ? DIV_W'(rem_sum - {1'b0, den}) : rem_sum[DIV_W-1:0];
  assign pos_int_next      = pos_int + LEN_W'(ratio_q) + LEN_W'(rem_wrap);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && !ratio_pending;

  // shared divider: step ratio after configuration, fraction per interpolated output
  assign ratio_start = (state == ST_IDLE) && ratio_pending && (den != '0) && (n_len != '0);
  assign frac_start  = (state == ST_CHECK) && more && run_open &&
                       (pos_int < input_count) && (den != '0);
  assign div_cmd = '{start: ratio_start || frac_start,
                     steps: (state == ST_CHECK) ? STEP_W'(FRAC_W) : STEP_W'(DIV_W)};
  assign div_rem_init  = (state == ST_CHECK) ? pos_rem : '0;
  assign div_dividend  = (state == ST_CHECK) ? '0 : n_m1;

  lir_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .divisor  (den),
    .rem_init (div_rem_init),
    .dividend (div_dividend),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // interpolation starts when the fraction is ready, or at once with a zero fraction
  assign lerp_start = ((state == ST_FRAC) && div_done) ||
                      ((state == ST_CHECK) && more && run_open &&
                       (pos_int < input_count) && (den == '0));
  assign lerp_frac  = (state == ST_FRAC) ? div_quot[FRAC_W-1:0] : '0;

  lir_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .a      (prev_sample),
    .b      (cur_sample),
    .frac   (lerp_frac),
    .done   (lerp_done),
    .result (lerp_result)
  );

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      source_length <= '0;
      target_length <= '0;
      ratio_pending <= 1'b0;
      ratio_q       <= '0;
      ratio_r       <= '0;
      prev_sample   <= '0;
      input_count   <= '0;
      output_index  <= '0;
      pos_int       <= '0;
      pos_rem       <= '0;
      run_count     <= '0;
      out_valid     <= 1'b0;
    end else begin
      // output transfer empties the register unless a new result loads it
      if (out_valid && out_ready && (cfg_write || (state != ST_PUT))) begin
        out_valid <= 1'b0;
      end

      if (cfg_write) begin
        // register write restarts the block and recomputes the step ratio
        if (cfg_index == REG_SOURCE_LENGTH) begin
          source_length <= cfg_data;
        end
        if (cfg_index == REG_TARGET_LENGTH) begin
          target_length <= cfg_data;
        end
        input_count   <= '0;
        output_index  <= '0;
        pos_int       <= '0;
        pos_rem       <= '0;
        ratio_pending <= 1'b1;
        state         <= ST_IDLE;
      end else begin
        case (state)
          ST_IDLE: begin
            if (ratio_pending) begin
              if (ratio_start) begin
                state <= ST_RATIO;
              end else begin
                ratio_q       <= '0;
                ratio_r       <= '0;
                ratio_pending <= 1'b0;
              end
            end else if (in_valid) begin
              if ((n_len != '0) && (m_len != '0) && (input_count < n_len)) begin
                cur_sample <= sample;
                run_count  <= '0;
                state      <= ST_CHECK;
              end
            end
          end

          ST_RATIO: begin
            if (div_done) begin
              ratio_q       <= div_quot;
              ratio_r       <= div_rem;
              ratio_pending <= 1'b0;
              state         <= ST_IDLE;
            end
          end

          ST_CHECK: begin
            if (more) begin
              if (run_open) begin
                if (pos_int < input_count) begin
                  state <= (den != '0) ? ST_FRAC : ST_MUL;
                end else begin
                  result <= cur_sample;
                  state  <= ST_ADV;
                end
              end else begin
                // past the cap: skip the output, keep the position moving
                output_index <= output_index_next;
                if (step_on) begin
                  pos_rem <= pos_rem_next;
                  pos_int <= pos_int_next;
                end
              end
            end else begin
              prev_sample <= cur_sample;
              input_count <= input_count + LEN_W'(1);
              state       <= ST_IDLE;
            end
          end

          ST_FRAC: begin
            if (div_done) begin
              state <= ST_MUL;
            end
          end

          ST_MUL: begin
            if (lerp_done) begin
              result <= lerp_result;
              state  <= ST_ADV;
            end
          end

          ST_ADV: begin
            output_index <= output_index_next;
            if (step_on) begin
              pos_rem <= pos_rem_next;
              pos_int <= pos_int_next;
            end
            run_count <= run_count + RUN_W'(1);
            state     <= ST_PUT;
          end

          ST_PUT: begin
            if (out_free) begin
              out_valid <= 1'b1;
              value     <= result;
              last      <= !(more && run_open);
              state     <= ST_CHECK;
            end
          end

          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  // position remainder always stays below the denominator
  `LIR_ASSERT_IMPLY(a_rem_below_den, clk, rst, den != '0, pos_rem < den)
  // never more inputs counted than the block length
  `LIR_ASSERT_IMPLY(a_count_in_block, clk, rst, 1'b1, input_count <= n_len)
  // results per input never pass the cap
  `LIR_ASSERT_IMPLY(a_run_capped, clk, rst, 1'b1, run_count <= RUN_W'(MAX_RUN))
  // a result leaving the sequencer shows up on the output register
  `LIR_ASSERT_NEXT(a_put_loads, clk, rst, (state == ST_PUT) && out_free && !cfg_write, out_valid)

endmodule

### sim/linear_interp_resampler_test.sv
// self-checking testbench for linear_interp_resampler: a scoreboard class predicts the
// interpolated samples of each block and checks every output transfer against them
// depends on lir_pkg and the resampler rtl
`timescale 1ns / 1ps

module linear_interp_resampler_test import lir_pkg::*;;

  localparam int RANDOM_ITEMS  = 300;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 4000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       last;
  } point_t;

  // predicts the output points of a block and checks the ones that come out
  class resample_scoreboard;
    logic [LEN_W-1:0]           src_len;
    logic [LEN_W-1:0]           tgt_len;
    logic signed [SAMPLE_W-1:0] held_sample;
    int unsigned                taken;
    int unsigned                next_out;
    int unsigned                pos_whole;
    int unsigned                pos_rem;
    point_t                     due_points[$];
    int                         mismatches = 0;

    // a new block starts, the previous sample is kept
    function void restart_block();
      taken = 0;
      next_out = 0;
      pos_whole = 0;
      pos_rem = 0;
    endfunction

    function void clear();
      src_len = '0;
      tgt_len = '0;
      held_sample = '0;
      due_points.delete();
      restart_block();
    endfunction

    function void set_length(logic [CFG_IDX_W-1:0] index, logic [LEN_W-1:0] data_word);
      if (index == REG_SOURCE_LENGTH) begin
        src_len = data_word;
      end else begin
        tgt_len = data_word;
      end
      restart_block();
    endfunction

    function int waiting();
      return due_points.size();
    endfunction

    // queue the points that this sample makes due
    function void predict_points(logic signed [SAMPLE_W-1:0] s);
      int unsigned n, m, den, q, r, frac;
      int          emitted;
      bit          due;
      longint      diff, step;
      point_t      p;
      n = (src_len > MAX_LENGTH) ? MAX_LENGTH : src_len;
      m = (tgt_len > MAX_LENGTH) ? MAX_LENGTH : tgt_len;
      if (n == 0 || m == 0 || taken >= n) return;
      den = m - 1;
      q = (den != 0) ? (n - 1) / den : 0;
      r = (den != 0) ? (n - 1) % den : 0;
      emitted = 0;
      while (next_out < m) begin
        due = (pos_whole < taken) || (pos_whole == taken && pos_rem == 0);
        if (!due) break;
        if (emitted < MAX_RUN) begin
          if (pos_whole < taken) begin
            frac = (den != 0) ? int'((longint'(pos_rem) << FRAC_W) / longint'(den)) : 0;
            diff = longint'(s) - longint'(held_sample);
            // round to nearest, ties toward plus infinity
            step = (diff * longint'(frac) + 64'sd32768) >>> FRAC_W;
            p.value = SAMPLE_W'(longint'(held_sample) + step);
          end else begin
            p.value = s;
          end
          p.last = 1'b0;
          due_points.insert(due_points.size(), p);
          emitted++;
        end
        // past the run cap the position still advances
        next_out++;
        if (next_out < m) begin
          pos_rem += r;
          if (pos_rem >= den) begin
            pos_rem -= den;
            pos_whole++;
          end
          pos_whole += q;
        end
      end
      if (emitted > 0) due_points[due_points.size()-1].last = 1'b1;
      held_sample = s;
      taken++;
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_point(logic signed [SAMPLE_W-1:0] got_value, logic got_last);
      point_t want;
      if (due_points.size() == 0) begin
        report($sformatf("unexpected output value %0d last %0b", got_value, got_last));
        return;
      end
      want = due_points.pop_front();
      if (got_value !== want.value)
        report($sformatf("value %0d, expected %0d", got_value, want.value));
      if (got_last !== want.last)
        report($sformatf("last %0b, expected %0b", got_last, want.last));
    endtask
  endclass

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [LEN_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] value;
  logic                       last;

  resample_scoreboard sb = new();
  bit  calm = 1'b0;
  bit  hold_outputs = 1'b0;
  int  quiet = 0;

  linear_interp_resampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .last      (last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // follow every transfer and register write into the scoreboard
  always @(posedge clk) begin
    if (rst) begin
      sb.clear();
    end else begin
      if (cfg_write) sb.set_length(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.predict_points(sample);
      if (out_valid && out_ready) sb.check_point(value, last);
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == STALL_LIMIT) begin
        $display("linear_interp_resampler regression: fail");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold-off on request, none when calm
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_outputs) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_outputs = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task write_reg(logic [CFG_IDX_W-1:0] index, logic [LEN_W-1:0] data_word);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data_word;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task set_lengths(int unsigned n, int unsigned m);
    if ($urandom_range(0, 1)) begin
      write_reg(REG_SOURCE_LENGTH, LEN_W'(n));
      write_reg(REG_TARGET_LENGTH, LEN_W'(m));
    end else begin
      write_reg(REG_TARGET_LENGTH, LEN_W'(m));
      write_reg(REG_SOURCE_LENGTH, LEN_W'(n));
    end
  endtask

  // one input transfer, after an optional gap; returns at the accepting edge
  task feed(logic signed [SAMPLE_W-1:0] s);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      sample   <= SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every predicted point has come out
  task drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.waiting() != 0);
    @(posedge clk);
  endtask

  // wait until dropped points and the length division are done and the block is idle
  task settle();
    drain();
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int unsigned n, m;
    int          count, extra, i, random_items;
    random_items = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty block straight out of reset
    feed(SAMPLE_W'(-1));
    settle();
    // extremes, interpolation between them, then an excess input
    set_lengths(3, 5);
    feed(SAMPLE_MAX);
    feed(SAMPLE_MIN);
    feed(SAMPLE_W'(0));
    feed(SAMPLE_W'(12345));
    settle();
    // half-way points with a negative tie
    set_lengths(2, 3);
    feed(SAMPLE_W'(3));
    feed(SAMPLE_W'(-2));
    settle();
    // single output
    set_lengths(2, 1);
    feed(SAMPLE_W'(7));
    feed(SAMPLE_W'(9));
    settle();
    // single input repeated past the run cap
    set_lengths(1, 70);
    feed(SAMPLE_W'(100));
    settle();
    // both lengths zero
    set_lengths(0, 0);
    feed(SAMPLE_W'(1));
    settle();
    // oversized lengths clamp to the same size
    set_lengths((1 << LEN_W) - 1, (1 << LEN_W) - 1);
    repeat (4) feed(rand_sample());
    settle();
    set_lengths(MAX_LENGTH, 2);
    feed(SAMPLE_MAX);
    feed(SAMPLE_MIN);
    settle();
    // interpolated run cap
    set_lengths(2, 200);
    feed(SAMPLE_MIN);
    feed(SAMPLE_MAX);
    settle();

    // long output hold-off while inputs keep coming
    set_lengths(40, 40);
    hold_outputs = 1'b1;
    repeat (40) feed(rand_sample());
    settle();
    random_items += 40;

    // random blocks, mostly complete, some cut short or overfed
    while (random_items < RANDOM_ITEMS) begin
      calm = (random_items >= RANDOM_ITEMS * 5 / 6);
      case ($urandom_range(0, 9))
        0: begin
          n = $urandom_range(1, 3);
          m = $urandom_range(65, 150);
        end
        1: begin
          n = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
          m = (n == 0) ? $urandom_range(0, 8) : 0;
        end
        2: begin
          n = $urandom_range(2, 30);
          m = n;
        end
        3: begin
          n = $urandom_range(1, 12);
          m = 1;
        end
        default: begin
          n = $urandom_range(1, 16);
          m = $urandom_range(2, 24);
        end
      endcase
      set_lengths(n, m);
      count = n;
      extra = 0;
      if ($urandom_range(0, 7) == 0) count = $urandom_range(0, n);
      else if ($urandom_range(0, 5) == 0) extra = $urandom_range(1, 3);
      for (i = 0; i < count + extra; i++) begin
        if (count > 1 && i == count / 2 && $urandom_range(0, 7) == 0) drain();
        feed(rand_sample());
        if (n > 0 && m > 0 && i < n) random_items++;
      end
      settle();
    end

    calm = 1'b1;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("linear_interp_resampler regression: pass");
    end else begin
      $display("linear_interp_resampler regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/lir_pkg.sv
rtl/lir_div.sv
rtl/lir_lerp.sv
rtl/linear_interp_resampler.sv
sim/linear_interp_resampler_test.sv
